// ===== hdl/ptgf_pkg.sv =====
// ---------------------------------------------------------------------------
// ptgf_pkg
// Shared types, constants and tables of the thrust controller.
// ---------------------------------------------------------------------------
`default_nettype none

package ptgf_pkg;

  localparam int ANGLE_FRAC_BITS = 13;
  localparam int SQRT_ITERATIONS = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_DERIV_GAIN   = 3'd2,
    REG_FORCE_MAX    = 3'd3,
    REG_FORCE_MIN    = 3'd4,
    REG_TICK_PERIOD  = 3'd5,
    REG_TICK_RATE_HZ = 3'd6
  } ptgf_reg_t;

  typedef enum logic [1:0] {
    CMD_MEASURE = 2'd0,
    CMD_TARGET  = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_UNUSED  = 2'd3
  } ptgf_cmd_t;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [15:0] deriv_gain;
    logic [15:0] force_max;
    logic [15:0] force_min;
    logic [15:0] tick_period;
    logic [9:0]  tick_rate_hz;
  } ptgf_cfg_t;

  localparam logic [63:0] PI_Q30    = 64'd3373259426;
  localparam logic [63:0] PI_Q_FULL =
    (PI_Q30 + (64'd1 << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS);
  localparam logic signed [17:0] PI_Q      = 18'(PI_Q_FULL);
  localparam logic signed [17:0] TWO_PI_Q  = 18'(2 * PI_Q_FULL);
  localparam logic signed [17:0] HALF_PI_Q = 18'(PI_Q_FULL / 2);

  localparam logic [32:0] DEG2RAD_Q32 = 33'd74961321;
  localparam logic [32:0] GRAV_FF_Q16 = 33'd734752;
  localparam logic [32:0] FORCE_TO_N  = 33'd2000;
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic signed [23:0] INTEG_LIMIT = 24'sd5242880;
  localparam logic signed [56:0] FF_BIAS_Q28 = 57'sd1342177280;
  localparam logic [32:0] SPEED_CAP   = 33'd50240;
  localparam logic [13:0] DEG_LIMIT   = 14'd11520;
  localparam logic [15:0] FORCE_FLOOR = 16'd3;

  localparam int DEG_SHIFT   = 39 - ANGLE_FRAC_BITS;
  localparam int INTEG_SHIFT = ANGLE_FRAC_BITS - 4;
  localparam int PD_SHIFT    = 20 - ANGLE_FRAC_BITS;
  localparam int SIN_SHIFT   = 30 - ANGLE_FRAC_BITS;

  // Taylor divisors, innermost term first, and floor(2^32 / divisor)
  function automatic logic [32:0] taylor_div(input logic [2:0] idx);
    logic [32:0] v;
    case (idx)
      3'd0:    v = 33'd110;
      3'd1:    v = 33'd72;
      3'd2:    v = 33'd42;
      3'd3:    v = 33'd20;
      default: v = 33'd6;
    endcase
    return v;
  endfunction

  function automatic logic [32:0] taylor_recip(input logic [2:0] idx);
    logic [32:0] v;
    case (idx)
      3'd0:    v = 33'd39045157;
      3'd1:    v = 33'd59652323;
      3'd2:    v = 33'd102261126;
      3'd3:    v = 33'd214748364;
      default: v = 33'd715827882;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ptgf_mul.sv =====
// ---------------------------------------------------------------------------
// ptgf_mul
// Shared signed 33x33 multiplier with a registered product.
// ---------------------------------------------------------------------------
`default_nettype none

module ptgf_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] mul_a,
  input  wire logic signed [32:0] mul_b,
  output logic signed [65:0]      mul_p
);

  logic signed [65:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign mul_p = prod_r;

endmodule

`default_nettype wire

// ===== hdl/ptgf_regs.sv =====
// ---------------------------------------------------------------------------
// ptgf_regs
// Configuration register file: gains, force limits, period and rate.
// ---------------------------------------------------------------------------
`default_nettype none

module ptgf_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [ptgf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [ptgf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ptgf_pkg::ptgf_cfg_t                  cfg
);

  ptgf_pkg::ptgf_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain    <= 16'd6400;
      cfg_r.integ_gain   <= 16'd205;
      cfg_r.deriv_gain   <= 16'd3072;
      cfg_r.force_max    <= 16'd11520;
      cfg_r.force_min    <= 16'd0;
      cfg_r.tick_period  <= 16'd655;
      cfg_r.tick_rate_hz <= 10'd100;
    end else if (cfg_wr_en) begin
      unique case (ptgf_pkg::ptgf_reg_t'(cfg_addr))
        ptgf_pkg::REG_PROP_GAIN:    cfg_r.prop_gain    <= cfg_wdata;
        ptgf_pkg::REG_INTEG_GAIN:   cfg_r.integ_gain   <= cfg_wdata;
        ptgf_pkg::REG_DERIV_GAIN:   cfg_r.deriv_gain   <= cfg_wdata;
        ptgf_pkg::REG_FORCE_MAX:    cfg_r.force_max    <= cfg_wdata;
        ptgf_pkg::REG_FORCE_MIN:    cfg_r.force_min    <= cfg_wdata;
        ptgf_pkg::REG_TICK_PERIOD:  cfg_r.tick_period  <= cfg_wdata;
        ptgf_pkg::REG_TICK_RATE_HZ: cfg_r.tick_rate_hz <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hdl/pid_thrust_with_gravity_feedforward.sv =====
// ---------------------------------------------------------------------------
// pid_thrust_with_gravity_feedforward
// PID arm-angle controller with gravity feedforward and propeller speed.
//
// channel | dir | tdata                                      | tuser
// in_     | in  | measured_angle[15:0] target_degrees[31:16] | cmd[1:0]
// out_    | out | thrust_force[15:0] motor_speed[31:16]      | active[0]
// cfg_    | in  | write enable, register index, write data
//
// A tick word runs in turn on the one shared multiplier: error terms, five
// Taylor steps of the sine, bit-serial root. The root is skipped when the
// force rounds below three LSBs, and all of these before any measurement.
// Reset (synchronous, rst_n low) clears state and loads register defaults.
// in_tready is low while a word is in work; a finished result waits in the
// output register and a tick result holds until that register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module pid_thrust_with_gravity_feedforward #(
  parameter int SQRT_ITERATIONS = ptgf_pkg::SQRT_ITERATIONS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [31:0]                     in_tdata,  // measured_angle, target_degrees
  input  wire logic [1:0]                      in_tuser,  // cmd
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [31:0]                          out_tdata, // thrust_force, motor_speed
  output logic                                 out_tuser, // active
  input  wire logic                            cfg_wr_en,
  input  wire logic [ptgf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [ptgf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int BIT_W = $clog2(SQRT_ITERATIONS);

  typedef enum logic [23:0] {
    S_IDLE = 24'd1 << 0,  S_TGT = 24'd1 << 1,  S_TGR = 24'd1 << 2,
    S_ERR  = 24'd1 << 3,  S_MI  = 24'd1 << 4,  S_MD  = 24'd1 << 5,
    S_MP   = 24'd1 << 6,  S_MK  = 24'd1 << 7,  S_MKD = 24'd1 << 8,
    S_MX   = 24'd1 << 9,  S_T0  = 24'd1 << 10, S_TA  = 24'd1 << 11,
    S_TB   = 24'd1 << 12, S_TC  = 24'd1 << 13, S_TD  = 24'd1 << 14,
    S_SX   = 24'd1 << 15, S_SF  = 24'd1 << 16, S_FF  = 24'd1 << 17,
    S_CL   = 24'd1 << 18, S_SN  = 24'd1 << 19, S_SQ0 = 24'd1 << 20,
    S_SA   = 24'd1 << 21, S_SB  = 24'd1 << 22, S_OUT = 24'd1 << 23
  } state_t;

  ptgf_pkg::ptgf_cfg_t cfg;

  state_t                     state_r, state_nxt;
  logic signed [15:0]         target_r, arm_r, last_r, err_r;
  logic signed [23:0]         integ_r;
  logic                       seen_r, act_r;
  logic [13:0]                deg_mag_r;
  logic                       deg_neg_r;
  logic [30:0]                x_r, t_r;
  logic [31:0]                v_r, q_r;
  logic [2:0]                 idx_r;
  logic signed [27:0]         d_r;
  logic signed [55:0]         acc_r;
  logic signed [56:0]         f_r;
  logic [15:0]                fq_r;
  logic [26:0]                n_r;
  logic [SQRT_ITERATIONS-1:0] root_r;
  logic [BIT_W-1:0]           bit_r;
  logic [31:0]                x2_r;
  logic                       out_valid_r;
  logic [31:0]                out_data_r;
  logic                       out_user_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  logic                       in_acc;
  logic signed [15:0]         in_deg;
  logic [13:0]                deg_mag;
  logic signed [17:0]         err_raw, err_wrap, arm_abs, fold_a;
  logic signed [16:0]         err_diff;
  logic [32:0]                prod_mag;
  logic [23:0]                step_mag;
  logic signed [25:0]         integ_sum;
  logic signed [23:0]         integ_new;
  logic [14:0]                tgt_mag;
  logic signed [56:0]         fmax, fmin, f_clamp;
  logic [36:0]                f_round;
  logic [15:0]                fq_new;
  logic [32:0]                tay_rem;
  logic [31:0]                q_fix;
  logic [SQRT_ITERATIONS-1:0] root_try;
  logic [15:0]                speed;
  logic                       out_free;

  ptgf_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ptgf_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // target clamp to +-90 degrees
  always_comb begin
    in_deg  = $signed(in_tdata[31:16]);
    deg_mag = (in_deg < 0) ? 14'(-17'(in_deg) > 17'(ptgf_pkg::DEG_LIMIT) ?
                                17'(ptgf_pkg::DEG_LIMIT) : -17'(in_deg))
                           : ((in_deg > $signed({2'b00, ptgf_pkg::DEG_LIMIT})) ?
                                ptgf_pkg::DEG_LIMIT : in_deg[13:0]);
  end

  // error wrap and sine argument fold
  always_comb begin
    err_raw  = 18'(target_r) - 18'(arm_r);
    err_wrap = err_raw;
    if (err_raw > ptgf_pkg::PI_Q) begin
      err_wrap = err_raw - ptgf_pkg::TWO_PI_Q;
    end else if (err_raw < -ptgf_pkg::PI_Q) begin
      err_wrap = err_raw + ptgf_pkg::TWO_PI_Q;
    end
    arm_abs = (arm_r < 0) ? -18'(arm_r) : 18'(arm_r);
    fold_a  = (arm_abs >= ptgf_pkg::PI_Q) ? arm_abs - ptgf_pkg::PI_Q : arm_abs;
    if (fold_a > ptgf_pkg::HALF_PI_Q) begin
      fold_a = ptgf_pkg::PI_Q - fold_a;
    end
  end

  // datapath helpers fed by the product register
  always_comb begin
    err_diff  = 17'(err_r) - 17'(last_r);
    prod_mag  = mul_p[65] ? 33'(-mul_p) : 33'(mul_p);
    step_mag  = 24'((prod_mag + 33'(1 << (ptgf_pkg::INTEG_SHIFT - 1)))
                    >> ptgf_pkg::INTEG_SHIFT);
    integ_sum = mul_p[65] ? 26'(integ_r) - 26'(step_mag) : 26'(integ_r) + 26'(step_mag);
    if (integ_sum > 26'(ptgf_pkg::INTEG_LIMIT)) begin
      integ_new = ptgf_pkg::INTEG_LIMIT;
    end else if (integ_sum < -26'(ptgf_pkg::INTEG_LIMIT)) begin
      integ_new = -ptgf_pkg::INTEG_LIMIT;
    end else begin
      integ_new = 24'(integ_sum);
    end
    tgt_mag  = 15'((mul_p + 66'(1 << (ptgf_pkg::DEG_SHIFT - 1))) >> ptgf_pkg::DEG_SHIFT);
    fmax     = 57'({cfg.force_max, 20'b0});
    fmin     = 57'({cfg.force_min, 20'b0});
    f_clamp  = (f_r > fmax) ? fmax : f_r;
    f_clamp  = (f_clamp < fmin) ? fmin : f_clamp;
    f_round  = 37'(f_clamp) + 37'(1 << 19);
    fq_new   = f_round[35:20];
    tay_rem  = 33'(v_r) - 33'(mul_p);
    q_fix    = (tay_rem >= ptgf_pkg::taylor_div(idx_r)) ? q_r + 32'd1 : q_r;
    root_try = root_r | (SQRT_ITERATIONS'(1) << bit_r);
    speed    = (33'(root_r) > ptgf_pkg::SPEED_CAP) ? 16'(ptgf_pkg::SPEED_CAP)
                                                   : 16'(root_r);
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_TGT: begin
        mul_a = 33'(deg_mag_r);
        mul_b = ptgf_pkg::DEG2RAD_Q32;
      end
      S_MI: begin
        mul_a = 33'(err_r);
        mul_b = 33'(cfg.tick_period);
      end
      S_MD: begin
        mul_a = 33'(err_diff);
        mul_b = 33'(cfg.tick_rate_hz);
      end
      S_MP: begin
        mul_a = 33'(cfg.prop_gain);
        mul_b = 33'(err_r);
      end
      S_MK: begin
        mul_a = 33'(cfg.integ_gain);
        mul_b = 33'(integ_r);
      end
      S_MKD: begin
        mul_a = 33'(cfg.deriv_gain);
        mul_b = 33'(d_r);
      end
      S_MX: begin
        mul_a = 33'(x_r);
        mul_b = 33'(x_r);
      end
      S_TA: begin
        mul_a = 33'(x2_r);
        mul_b = 33'(t_r);
      end
      S_TB: begin
        mul_a = 33'(mul_p[61:30]);
        mul_b = ptgf_pkg::taylor_recip(idx_r);
      end
      S_TC: begin
        mul_a = 33'(mul_p[63:32]);
        mul_b = ptgf_pkg::taylor_div(idx_r);
      end
      S_SX: begin
        mul_a = 33'(x_r);
        mul_b = 33'(t_r);
      end
      S_SF: begin
        mul_a = 33'(mul_p[60:30]);
        mul_b = ptgf_pkg::GRAV_FF_Q16;
      end
      S_SN: begin
        mul_a = 33'(fq_r);
        mul_b = ptgf_pkg::FORCE_TO_N;
      end
      S_SA: begin
        mul_a = 33'(root_try);
        mul_b = 33'(root_try);
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (ptgf_pkg::ptgf_cmd_t'(in_tuser))
            ptgf_pkg::CMD_TARGET: state_nxt = S_TGT;
            ptgf_pkg::CMD_TICK:   state_nxt = seen_r ? S_ERR : S_OUT;
            default:              state_nxt = S_IDLE;
          endcase
        end
      end
      S_TGT: state_nxt = S_TGR;
      S_TGR: state_nxt = S_IDLE;
      S_ERR: state_nxt = S_MI;
      S_MI:  state_nxt = S_MD;
      S_MD:  state_nxt = S_MP;
      S_MP:  state_nxt = S_MK;
      S_MK:  state_nxt = S_MKD;
      S_MKD: state_nxt = S_MX;
      S_MX:  state_nxt = S_T0;
      S_T0:  state_nxt = S_TA;
      S_TA:  state_nxt = S_TB;
      S_TB:  state_nxt = S_TC;
      S_TC:  state_nxt = S_TD;
      S_TD:  state_nxt = (idx_r == 3'd4) ? S_SX : S_TA;
      S_SX:  state_nxt = S_SF;
      S_SF:  state_nxt = S_FF;
      S_FF:  state_nxt = S_CL;
      S_CL:  state_nxt = (fq_new >= ptgf_pkg::FORCE_FLOOR) ? S_SN : S_OUT;
      S_SN:  state_nxt = S_SQ0;
      S_SQ0: state_nxt = S_SA;
      S_SA:  state_nxt = S_SB;
      S_SB:  state_nxt = (bit_r == '0) ? S_OUT : S_SA;
      S_OUT: state_nxt = out_free ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      target_r    <= '0;
      arm_r       <= '0;
      integ_r     <= '0;
      last_r      <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && ptgf_pkg::ptgf_cmd_t'(in_tuser) == ptgf_pkg::CMD_MEASURE) begin
            arm_r  <= $signed(in_tdata[15:0]);
            seen_r <= 1'b1;
          end
        end
        S_TGR: begin
          target_r <= deg_neg_r ? -16'(tgt_mag) : 16'(tgt_mag);
          integ_r  <= '0;
        end
        S_MD: integ_r <= integ_new;
        S_OUT: begin
          if (out_free && act_r) begin
            last_r <= err_r;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        deg_mag_r <= deg_mag;
        deg_neg_r <= in_deg[15];
        act_r     <= 1'b0;
        fq_r      <= '0;
        root_r    <= '0;
      end
      S_ERR: begin
        err_r <= 16'(err_wrap);
        x_r   <= 31'(fold_a) << ptgf_pkg::SIN_SHIFT;
        act_r <= 1'b1;
      end
      S_MP:  d_r   <= 28'(mul_p);
      S_MK:  acc_r <= 56'(mul_p) <<< ptgf_pkg::PD_SHIFT;
      S_MKD: acc_r <= acc_r + 56'(mul_p);
      S_MX:  acc_r <= acc_r + (56'(mul_p) <<< ptgf_pkg::PD_SHIFT);
      S_T0: begin
        x2_r  <= mul_p[61:30];
        t_r   <= ptgf_pkg::Q30_ONE;
        idx_r <= '0;
      end
      S_TB: v_r <= mul_p[61:30];
      S_TC: q_r <= mul_p[63:32];
      S_TD: begin
        t_r   <= ptgf_pkg::Q30_ONE - 31'(q_fix);
        idx_r <= idx_r + 3'd1;
      end
      S_FF: f_r <= 57'(acc_r) + ptgf_pkg::FF_BIAS_Q28
                   + 57'((mul_p + 66'sd131072) >>> 18);
      S_CL: begin
        fq_r   <= fq_new;
        root_r <= '0;
      end
      S_SQ0: begin
        n_r    <= mul_p[26:0];
        root_r <= '0;
        bit_r  <= BIT_W'(SQRT_ITERATIONS - 1);
      end
      S_SB: begin
        if ($unsigned(mul_p) <= 66'(n_r)) begin
          root_r <= root_try;
        end
        bit_r <= bit_r - BIT_W'(1);
      end
      S_OUT: begin
        if (out_free) begin
          out_data_r <= {speed, fq_r};
          out_user_r <= act_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 32'd0)
    else $error("inactive result carries nonzero data");

  a_speed_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 33'(out_tdata[31:16]) <= ptgf_pkg::SPEED_CAP)
    else $error("speed above cap");

  a_low_force: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[15:0] < ptgf_pkg::FORCE_FLOOR |-> out_tdata[31:16] == 16'd0)
    else $error("speed nonzero at negligible force");

  a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    integ_r <= ptgf_pkg::INTEG_LIMIT && integ_r >= -ptgf_pkg::INTEG_LIMIT)
    else $error("integral outside clamp");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == ptgf_pkg::CMD_TICK |=> !in_tready)
    else $error("ready right after a tick");

endmodule

`default_nettype wire
